// File: hw/rtl/alias_multinomial_sampler_unit_macros.svh
// ----------------------------------------------------------------------------
// Alias sampler assertion macros
// Concurrent assertion shorthands; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ALIAS_MULTINOMIAL_SAMPLER_UNIT_MACROS_SVH
`define ALIAS_MULTINOMIAL_SAMPLER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is low
`define AMS_ASSERT_IMP(name, clk, rst_n, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);
// Next-cycle implication, disabled while reset is low
`define AMS_ASSERT_NXT(name, clk, rst_n, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);
`else
`define AMS_ASSERT_IMP(name, clk, rst_n, pre, post, msg)
`define AMS_ASSERT_NXT(name, clk, rst_n, pre, post, msg)
`endif

`endif

// File: hw/rtl/ams_pkg.sv
// ----------------------------------------------------------------------------
// Alias sampler package
// Shared types, codes and constants of the alias multinomial sampler.
// ----------------------------------------------------------------------------
package ams_pkg;

  // Default sizes
  localparam int STREAMS_DEF = 8;
  localparam int MAX_CAT_DEF = 64;

  // Field widths
  localparam int KIND_W   = 2;
  localparam int STREAM_W = 3;
  localparam int ENTRY_W  = 6;
  localparam int CUT_W    = 33;
  localparam int ALIAS_W  = 6;
  localparam int SEED_W   = 32;
  localparam int DRAW_W   = 16;
  localparam int CAT_OUT_W = 6;
  localparam int NCAT_W   = 7;
  localparam int MUL_B_W  = 17;
  localparam int PROD_W   = SEED_W + MUL_B_W;

  // Generator constants
  localparam logic [MUL_B_W-1:0] LCG_MUL  = 17'd69069;
  localparam logic [SEED_W-1:0]  LCG_ZERO_FIX = 32'd12345671;
  localparam logic [CUT_W-1:0]   ONE_Q32  = 33'h1_0000_0000;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_ENTRY = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SEED  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DRAW  = 2'd2;

  // Register index (from paddr[2])
  localparam logic REG_CAT_CNT = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_STEP,
    ST_SCALE,
    ST_LOOK,
    ST_CNT_UPD,
    ST_EMIT_RD,
    ST_EMIT
  } state_t;

  typedef enum logic {
    MUL_LCG,
    MUL_SCALE
  } mul_op_t;

  typedef struct packed {
    logic [SEED_W-1:0] lcg_next;
    logic [NCAT_W-1:0] k;
    logic [SEED_W-1:0] frac;
  } mul_res_t;

endpackage

// File: hw/rtl/alias_multinomial_sampler_unit.sv
// ----------------------------------------------------------------------------
// Alias multinomial sampler
// Walker alias-method sampler over per-stream 32-bit congruential generators.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Kind 0 (table entry)
// and kind 1 (seed) requests finish in the cycle they are taken and never
// raise busy. A draw request holds busy until its last count is output: the
// load state copies the generator state, read when the request is taken, into
// the working register; each sample uses the one shared multiplier twice
// (generator step, then category scaling), waits for the registered table
// read and, if counted, does a read-modify-write of the count memory; each
// count result then takes a read state and an output state. Results appear on
// out_* for one cycle, flagged by out_strobe, and must be taken in that cycle
// since the receiver cannot stall the block.
// Count memory clearing is done at once through per-entry valid bits.
module alias_multinomial_sampler_unit #(
  parameter int STREAMS        = ams_pkg::STREAMS_DEF,
  parameter int MAX_CATEGORIES = ams_pkg::MAX_CAT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Request channel
  input  logic                           start,
  output logic                           busy,
  input  logic [ams_pkg::KIND_W-1:0]     in_kind,
  input  logic [ams_pkg::STREAM_W-1:0]   in_stream,
  input  logic [ams_pkg::ENTRY_W-1:0]    in_entry,
  input  logic [ams_pkg::CUT_W-1:0]      in_cutoff,
  input  logic [ams_pkg::ALIAS_W-1:0]    in_alias_target,
  input  logic [ams_pkg::SEED_W-1:0]     in_seed_value,
  input  logic [ams_pkg::DRAW_W-1:0]     in_draw_count,
  // Result channel
  output logic                           out_strobe,
  output logic [ams_pkg::CAT_OUT_W-1:0]  out_category,
  output logic [ams_pkg::DRAW_W-1:0]     out_count,
  output logic                           out_last,
  // Register port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

`include "alias_multinomial_sampler_unit_macros.svh"

  localparam int SIDX_W = (STREAMS > 1) ? $clog2(STREAMS) : 1;
  localparam int CAT_W  = $clog2(MAX_CATEGORIES);
  localparam int NW     = ams_pkg::NCAT_W;
  localparam int DW     = ams_pkg::DRAW_W;

  // Control and working registers
  ams_pkg::state_t                state_r, state_nxt;
  logic [SIDX_W-1:0]              sidx_r, sidx_nxt;
  logic [NW-1:0]                  n_r, n_nxt;
  logic [DW-1:0]                  draws_r, draws_nxt;
  logic [ams_pkg::SEED_W-1:0]     s_r, s_nxt;
  logic [CAT_W-1:0]               k_r, k_nxt;
  logic [ams_pkg::SEED_W-1:0]     frac_r, frac_nxt;
  logic [CAT_W-1:0]               tgt_r, tgt_nxt;
  logic [NW-1:0]                  emit_idx_r, emit_idx_nxt;
  logic [NW-1:0]                  cat_cnt_r, cat_cnt_nxt;
  logic [STREAMS-1:0]             gen_vld_r, gen_vld_nxt;
  logic [MAX_CATEGORIES-1:0]      cnt_vld_r, cnt_vld_nxt;

  // Memories and their registered read data
  logic [ams_pkg::SEED_W-1:0]     gen_mem [STREAMS];
  logic [ams_pkg::CUT_W-1:0]      cut_mem [MAX_CATEGORIES];
  logic [ams_pkg::ALIAS_W-1:0]    alias_mem [MAX_CATEGORIES];
  logic [DW-1:0]                  cnt_mem [MAX_CATEGORIES];
  logic [ams_pkg::SEED_W-1:0]     gen_q_r;
  logic                           gen_qv_r;
  logic [ams_pkg::CUT_W-1:0]      cut_q_r;
  logic [ams_pkg::ALIAS_W-1:0]    alias_q_r;
  logic [DW-1:0]                  cnt_q_r;
  logic                           cnt_qv_r;

  // Datapath signals
  logic                           accept;
  logic [ams_pkg::STREAM_W-1:0]   strm_mod;
  logic [SIDX_W-1:0]              sidx_in;
  logic [NW-1:0]                  n_eff;
  logic [ams_pkg::CUT_W-1:0]      cut_sat;
  logic                           entry_ok;
  logic                           cfg_wr;
  ams_pkg::mul_op_t               mul_op;
  ams_pkg::mul_res_t              mul_res;
  logic [ams_pkg::ALIAS_W-1:0]    target;
  logic                           target_ok;
  logic                           emit_last;

  logic                           gen_we;
  logic [SIDX_W-1:0]              gen_waddr;
  logic [ams_pkg::SEED_W-1:0]     gen_wdata;
  logic                           tbl_we;
  logic                           cnt_re;
  logic [CAT_W-1:0]               cnt_raddr;
  logic                           cnt_we;

  assign accept = start && !busy;
  assign busy   = (state_r != ams_pkg::ST_IDLE);

  // Fold the stream index into the stream range
  always_comb begin
    strm_mod = in_stream;
    for (int i = 0; i < 8; i++) begin
      if (int'(strm_mod) >= STREAMS) begin
        strm_mod = strm_mod - ams_pkg::STREAM_W'(STREAMS);
      end
    end
  end
  assign sidx_in = SIDX_W'(strm_mod);

  // Clamp the category count into 1..MAX_CATEGORIES
  always_comb begin
    if (cat_cnt_r == '0) begin
      n_eff = NW'(1);
    end else if (cat_cnt_r > NW'(MAX_CATEGORIES)) begin
      n_eff = NW'(MAX_CATEGORIES);
    end else begin
      n_eff = cat_cnt_r;
    end
  end

  // Saturate the cutoff at one
  assign cut_sat  = (in_cutoff > ams_pkg::ONE_Q32) ? ams_pkg::ONE_Q32 : in_cutoff;
  assign entry_ok = ({1'b0, in_entry} < NW'(MAX_CATEGORIES));

  // Register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == ams_pkg::REG_CAT_CNT);
  assign prdata = (paddr[2] == ams_pkg::REG_CAT_CNT) ? {25'd0, cat_cnt_r} : 32'd0;
  assign cat_cnt_nxt = cfg_wr ? pwdata[NW-1:0] : cat_cnt_r;

  // Shared multiplier
  assign mul_op = (state_r == ams_pkg::ST_SCALE) ? ams_pkg::MUL_SCALE : ams_pkg::MUL_LCG;

  ams_mul u_mul (
    .op   (mul_op),
    .opa  (s_r),
    .ncat (n_r),
    .res  (mul_res)
  );

  // Alias decision
  assign target    = ({1'b0, frac_r} <= cut_q_r) ? ams_pkg::ALIAS_W'(k_r) : alias_q_r;
  assign target_ok = ({1'b0, target} < n_r);
  assign emit_last = (emit_idx_r == n_r - NW'(1));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ams_pkg::ST_IDLE: begin
        if (accept && in_kind == ams_pkg::KIND_DRAW) begin
          state_nxt = ams_pkg::ST_LOAD;
        end
      end
      ams_pkg::ST_LOAD: begin
        state_nxt = (draws_r == '0) ? ams_pkg::ST_EMIT_RD : ams_pkg::ST_STEP;
      end
      ams_pkg::ST_STEP:  state_nxt = ams_pkg::ST_SCALE;
      ams_pkg::ST_SCALE: state_nxt = ams_pkg::ST_LOOK;
      ams_pkg::ST_LOOK: begin
        if (target_ok) begin
          state_nxt = ams_pkg::ST_CNT_UPD;
        end else begin
          state_nxt = (draws_r == '0) ? ams_pkg::ST_EMIT_RD : ams_pkg::ST_STEP;
        end
      end
      ams_pkg::ST_CNT_UPD: begin
        state_nxt = (draws_r == '0) ? ams_pkg::ST_EMIT_RD : ams_pkg::ST_STEP;
      end
      ams_pkg::ST_EMIT_RD: state_nxt = ams_pkg::ST_EMIT;
      ams_pkg::ST_EMIT: begin
        state_nxt = emit_last ? ams_pkg::ST_IDLE : ams_pkg::ST_EMIT_RD;
      end
      default: state_nxt = ams_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    sidx_nxt     = sidx_r;
    n_nxt        = n_r;
    draws_nxt    = draws_r;
    s_nxt        = s_r;
    k_nxt        = k_r;
    frac_nxt     = frac_r;
    tgt_nxt      = tgt_r;
    emit_idx_nxt = '0;
    gen_vld_nxt  = gen_vld_r;
    cnt_vld_nxt  = cnt_vld_r;
    gen_we       = 1'b0;
    gen_waddr    = sidx_r;
    gen_wdata    = mul_res.lcg_next;
    tbl_we       = 1'b0;
    cnt_re       = 1'b0;
    cnt_raddr    = target[CAT_W-1:0];
    cnt_we       = 1'b0;
    unique case (state_r)
      ams_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_kind)
            ams_pkg::KIND_ENTRY: tbl_we = entry_ok;
            ams_pkg::KIND_SEED: begin
              gen_we      = 1'b1;
              gen_waddr   = sidx_in;
              gen_wdata   = in_seed_value;
              gen_vld_nxt[sidx_in] = 1'b1;
            end
            ams_pkg::KIND_DRAW: begin
              sidx_nxt    = sidx_in;
              n_nxt       = n_eff;
              draws_nxt   = in_draw_count;
              cnt_vld_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      ams_pkg::ST_LOAD: s_nxt = gen_qv_r ? gen_q_r : '0;
      ams_pkg::ST_STEP: begin
        // Advance the generator and write it back
        s_nxt     = mul_res.lcg_next;
        gen_we    = 1'b1;
        gen_vld_nxt[sidx_r] = 1'b1;
        draws_nxt = draws_r - DW'(1);
      end
      ams_pkg::ST_SCALE: begin
        k_nxt    = mul_res.k[CAT_W-1:0];
        frac_nxt = mul_res.frac;
      end
      ams_pkg::ST_LOOK: begin
        tgt_nxt = target[CAT_W-1:0];
        cnt_re  = target_ok;
      end
      ams_pkg::ST_CNT_UPD: begin
        cnt_we = 1'b1;
        cnt_vld_nxt[tgt_r] = 1'b1;
      end
      ams_pkg::ST_EMIT_RD: begin
        emit_idx_nxt = emit_idx_r;
        cnt_re       = 1'b1;
        cnt_raddr    = emit_idx_r[CAT_W-1:0];
      end
      ams_pkg::ST_EMIT: emit_idx_nxt = emit_idx_r + NW'(1);
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ams_pkg::ST_IDLE;
      cat_cnt_r <= NW'(1);
      gen_vld_r <= '0;
      cnt_vld_r <= '0;
    end else begin
      state_r   <= state_nxt;
      cat_cnt_r <= cat_cnt_nxt;
      gen_vld_r <= gen_vld_nxt;
      cnt_vld_r <= cnt_vld_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    sidx_r     <= sidx_nxt;
    n_r        <= n_nxt;
    draws_r    <= draws_nxt;
    s_r        <= s_nxt;
    k_r        <= k_nxt;
    frac_r     <= frac_nxt;
    tgt_r      <= tgt_nxt;
    emit_idx_r <= emit_idx_nxt;
  end

  // Generator state memory
  always_ff @(posedge clk) begin
    if (gen_we) begin
      gen_mem[gen_waddr] <= gen_wdata;
    end
    if (accept) begin
      gen_q_r  <= gen_mem[sidx_in];
      gen_qv_r <= gen_vld_r[sidx_in];
    end
  end

  // Alias table memory
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      cut_mem[in_entry[CAT_W-1:0]]   <= cut_sat;
      alias_mem[in_entry[CAT_W-1:0]] <= in_alias_target;
    end
    if (state_r == ams_pkg::ST_SCALE) begin
      cut_q_r   <= cut_mem[mul_res.k[CAT_W-1:0]];
      alias_q_r <= alias_mem[mul_res.k[CAT_W-1:0]];
    end
  end

  // Count memory: read-modify-write, unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[tgt_r] <= (cnt_qv_r ? cnt_q_r : '0) + DW'(1);
    end
    if (cnt_re) begin
      cnt_q_r  <= cnt_mem[cnt_raddr];
      cnt_qv_r <= cnt_vld_r[cnt_raddr];
    end
  end

  // Result outputs
  assign out_strobe   = (state_r == ams_pkg::ST_EMIT);
  assign out_category = ams_pkg::CAT_OUT_W'(emit_idx_r);
  assign out_count    = cnt_qv_r ? cnt_q_r : '0;
  assign out_last     = emit_last;

  // Checks
  `AMS_ASSERT_IMP(a_strobe_in_run, clk, rst_n, out_strobe, busy, "result outside a run")
  `AMS_ASSERT_NXT(a_last_ends_run, clk, rst_n, out_strobe && out_last, !busy, "run did not end")
  `AMS_ASSERT_NXT(a_strobe_gap, clk, rst_n, out_strobe && !out_last, !out_strobe, "results too close")
  `AMS_ASSERT_NXT(a_draw_starts, clk, rst_n, start && !busy && in_kind == ams_pkg::KIND_DRAW, busy, "draw not started")

endmodule

// File: hw/rtl/ams_mul.sv
// ----------------------------------------------------------------------------
// Alias sampler shared multiplier
// One 32x17 multiplier used for the generator step and the category scaling.
// ----------------------------------------------------------------------------
module ams_mul (
  input  ams_pkg::mul_op_t                 op,
  input  logic [ams_pkg::SEED_W-1:0]       opa,
  input  logic [ams_pkg::NCAT_W-1:0]       ncat,
  output ams_pkg::mul_res_t                res
);

  logic [ams_pkg::MUL_B_W-1:0] opb;
  logic [ams_pkg::PROD_W-1:0]  prod;
  logic [ams_pkg::SEED_W-1:0]  lcg_sum;

  // Pick the second operand
  always_comb begin
    unique case (op)
      ams_pkg::MUL_LCG:   opb = ams_pkg::LCG_MUL;
      ams_pkg::MUL_SCALE: opb = ams_pkg::MUL_B_W'(ncat);
      default:            opb = ams_pkg::LCG_MUL;
    endcase
  end

  assign prod    = ams_pkg::PROD_W'(opa) * ams_pkg::PROD_W'(opb);
  assign lcg_sum = prod[ams_pkg::SEED_W-1:0] + 32'd1;

  // Replace a zero state, split the scaled product into index and fraction
  assign res.lcg_next = (lcg_sum == '0) ? ams_pkg::LCG_ZERO_FIX : lcg_sum;
  assign res.k        = prod[ams_pkg::SEED_W +: ams_pkg::NCAT_W];
  assign res.frac     = prod[ams_pkg::SEED_W-1:0];

endmodule
